// ===== hw/rtl/acfp_pkg.sv =====
// Shared types, codes and constants of the ASCII control frame parser.
package acfp_pkg;

	// Frame buffer and token layout
	localparam int BUFFER_BYTES = 32;
	localparam int FIELD_COUNT  = 6;
	localparam int CNT_W        = $clog2(BUFFER_BYTES);
	localparam int IDX_W        = 3;
	localparam int ACC_W        = 17;
	localparam int CAL_LEN      = 18;
	localparam int CAL_W        = 5;

	// Framing characters
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_END   = 8'h23;
	localparam logic [7:0] CH_SEP   = 8'h3B;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Operating modes
	localparam logic [1:0] MODE_STANDALONE = 2'd0;
	localparam logic [1:0] MODE_MASTER     = 2'd1;
	localparam logic [1:0] MODE_SLAVE      = 2'd2;
	localparam logic [1:0] MODE_NONE       = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_OP_MODE     = 2'd0;
	localparam logic [1:0] REG_DBG_MIN     = 2'd1;
	localparam logic [1:0] REG_DBG_MAX_LOC = 2'd2;
	localparam logic [1:0] REG_DBG_MAX_MST = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_PENDING = 2'd0;
	localparam logic [1:0] ST_ACCEPT  = 2'd1;
	localparam logic [1:0] ST_REJECT  = 2'd2;

	// Token parse phases
	localparam logic [1:0] PH_BETWEEN = 2'd0;
	localparam logic [1:0] PH_BLANK   = 2'd1;
	localparam logic [1:0] PH_NUMBER  = 2'd2;
	localparam logic [1:0] PH_SKIP    = 2'd3;

	typedef struct packed {
		logic [1:0] op_mode;
		logic [3:0] dbg_min;
		logic [3:0] dbg_max_loc;
		logic [3:0] dbg_max_mst;
	} cfg_t;

	// Packed so that the layout matches the output beat from bit 0 up
	typedef struct packed {
		logic [4:0] flags;
		logic [3:0] debug_mode;
		logic       ctrl_valid;
		logic       calib_request;
		logic [1:0] status;
	} res_t;

	// Characters of the calibration command
	function automatic logic [7:0] cal_char(input logic [CAL_W-1:0] pos);
		logic [7:0] ch;
		unique case (pos)
			5'd0:  ch = "T";
			5'd1:  ch = "R";
			5'd2:  ch = "I";
			5'd3:  ch = "G";
			5'd4:  ch = "G";
			5'd5:  ch = "E";
			5'd6:  ch = "R";
			5'd7:  ch = "C";
			5'd8:  ch = "A";
			5'd9:  ch = "L";
			5'd10: ch = "I";
			5'd11: ch = "B";
			5'd12: ch = "R";
			5'd13: ch = "A";
			5'd14: ch = "T";
			5'd15: ch = "I";
			5'd16: ch = "O";
			5'd17: ch = "N";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== hw/rtl/acfp_core.sv =====
// Frame state, token conversion and control word update for one byte per cycle in which step is high.
module acfp_core import acfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  logic       link,
	input  cfg_t       cfg,
	output res_t       res
);

	// Frame and token state
	logic             active_q, active_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [1:0]       phase_q, phase_d;
	logic             neg_q, neg_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic             ovf_q, ovf_d;
	logic             in_range_q, in_range_d;
	logic [3:0]       pdebug_q, pdebug_d;
	logic [4:0]       pflags_q, pflags_d;
	logic [CAL_W-1:0] cal_pos_q, cal_pos_d;
	logic             cal_ok_q, cal_ok_d;
	logic [3:0]       hdebug_q, hdebug_d;
	logic [4:0]       hflags_q, hflags_d;
	logic             hvalid_q, hvalid_d;

	// Token finish results
	logic             fin_ok;
	logic [IDX_W-1:0] fin_idx;
	logic             fin_range;
	logic [3:0]       fin_debug;
	logic [4:0]       fin_flags;
	logic [2:0]       flag_sel;

	logic             allowed;
	logic             is_blank, is_digit;
	logic [3:0]       digit;
	logic [ACC_W+3:0] acc_x10;
	logic             do_clear;
	logic             cal_hit;
	logic [3:0]       dmax;
	logic             frame_ok;
	logic [IDX_W-1:0] e_idx;
	logic             e_range;
	logic [3:0]       e_debug;
	logic [4:0]       e_flags;
	logic [1:0]       status;
	logic             calib;

	// Classify the character
	assign is_blank = (rx_byte == CH_SPACE) || (rx_byte >= CH_TAB && rx_byte <= CH_CR);
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign digit    = 4'(rx_byte - CH_ZERO);
	assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {17'd0, digit};
	assign allowed  = link ? (cfg.op_mode == MODE_SLAVE)
	                       : (cfg.op_mode == MODE_STANDALONE || cfg.op_mode == MODE_MASTER);

	// Close the current token: range check and store into the pending word
	always_comb begin
		fin_ok    = !ovf_q && (acc_q == '0 || !neg_q)
		            && (acc_q <= ((idx_q == '0) ? ACC_W'(15) : ACC_W'(1)));
		fin_idx   = idx_q;
		fin_range = in_range_q;
		fin_debug = pdebug_q;
		fin_flags = pflags_q;
		flag_sel  = idx_q - 3'd1;
		if (idx_q < IDX_W'(FIELD_COUNT)) begin
			if (idx_q == '0) begin
				fin_debug = acc_q[3:0];
			end else if (fin_ok) begin
				fin_flags[flag_sel] = pflags_q[flag_sel] | acc_q[0];
			end
			if (!fin_ok) begin
				fin_range = 1'b0;
			end
			fin_idx = idx_q + 3'd1;
		end
	end

	// Pending word as seen at the end mark
	always_comb begin
		if (phase_q != PH_BETWEEN) begin
			e_idx   = fin_idx;
			e_range = fin_range;
			e_debug = fin_debug;
			e_flags = fin_flags;
		end else begin
			e_idx   = idx_q;
			e_range = in_range_q;
			e_debug = pdebug_q;
			e_flags = pflags_q;
		end
	end

	assign cal_hit  = cal_ok_q && (cal_pos_q == CAL_W'(CAL_LEN));
	assign dmax     = (cfg.op_mode == MODE_MASTER) ? cfg.dbg_max_mst : cfg.dbg_max_loc;
	assign frame_ok = (e_idx >= IDX_W'(FIELD_COUNT)) && e_range
	                  && (e_debug >= cfg.dbg_min) && (e_debug <= dmax);

	// Next state for one byte
	always_comb begin
		active_d   = active_q;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		phase_d    = phase_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		ovf_d      = ovf_q;
		in_range_d = in_range_q;
		pdebug_d   = pdebug_q;
		pflags_d   = pflags_q;
		cal_pos_d  = cal_pos_q;
		cal_ok_d   = cal_ok_q;
		hdebug_d   = hdebug_q;
		hflags_d   = hflags_q;
		hvalid_d   = hvalid_q;
		do_clear   = 1'b0;
		status     = ST_PENDING;
		calib      = 1'b0;

		if (step) begin
			if (!allowed) begin
				status = ST_REJECT;
			end else if (rx_byte == CH_START) begin
				do_clear = 1'b1;
				active_d = 1'b1;
			end else if (rx_byte == CH_END) begin
				if (active_q) begin
					if (cal_hit) begin
						if (cfg.op_mode == MODE_STANDALONE) begin
							status = ST_ACCEPT;
							calib  = 1'b1;
						end else begin
							status = ST_REJECT;
						end
					end else if (frame_ok) begin
						hdebug_d = e_debug;
						hflags_d = e_flags;
						hvalid_d = 1'b1;
						status   = ST_ACCEPT;
					end else begin
						hvalid_d = 1'b0;
						status   = ST_REJECT;
					end
				end
				active_d = 1'b0;
				do_clear = 1'b1;
			end else if (active_q && rx_byte != CH_NUL) begin
				if (cnt_q >= CNT_W'(BUFFER_BYTES - 1)) begin
					// Buffer full: drop the frame
					active_d = 1'b0;
					do_clear = 1'b1;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
					// Track the calibration command
					if (cal_ok_q && cal_pos_q < CAL_W'(CAL_LEN)
					    && rx_byte == cal_char(cal_pos_q)) begin
						cal_pos_d = cal_pos_q + CAL_W'(1);
					end else begin
						cal_ok_d = 1'b0;
					end
					if (rx_byte == CH_SEP) begin
						if (phase_q != PH_BETWEEN) begin
							idx_d      = fin_idx;
							in_range_d = fin_range;
							pdebug_d   = fin_debug;
							pflags_d   = fin_flags;
							phase_d    = PH_BETWEEN;
							neg_d      = 1'b0;
							acc_d      = '0;
							ovf_d      = 1'b0;
						end
					end else if (idx_q < IDX_W'(FIELD_COUNT)) begin
						// Convert the token character by character
						unique case (phase_q)
							PH_BETWEEN, PH_BLANK: begin
								if (is_blank) begin
									phase_d = PH_BLANK;
								end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
									neg_d   = (rx_byte == CH_MINUS);
									phase_d = PH_NUMBER;
								end else if (is_digit) begin
									acc_d   = ACC_W'(digit);
									phase_d = PH_NUMBER;
								end else begin
									phase_d = PH_SKIP;
								end
							end
							PH_NUMBER: begin
								if (is_digit) begin
									if (acc_x10 > (ACC_W+4)'({ACC_W{1'b1}})) begin
										ovf_d = 1'b1;
									end else begin
										acc_d = acc_x10[ACC_W-1:0];
									end
								end else begin
									phase_d = PH_SKIP;
								end
							end
							default: begin
								phase_d = phase_q;
							end
						endcase
					end
				end
			end
		end

		// Start a fresh frame
		if (do_clear) begin
			cnt_d      = '0;
			idx_d      = '0;
			phase_d    = PH_BETWEEN;
			neg_d      = 1'b0;
			acc_d      = '0;
			ovf_d      = 1'b0;
			in_range_d = 1'b1;
			pdebug_d   = '0;
			pflags_d   = '0;
			cal_pos_d  = '0;
			cal_ok_d   = 1'b1;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			cnt_q      <= '0;
			idx_q      <= '0;
			phase_q    <= PH_BETWEEN;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			ovf_q      <= 1'b0;
			in_range_q <= 1'b1;
			pdebug_q   <= '0;
			pflags_q   <= '0;
			cal_pos_q  <= '0;
			cal_ok_q   <= 1'b1;
			hdebug_q   <= '0;
			hflags_q   <= '0;
			hvalid_q   <= 1'b0;
		end else begin
			active_q   <= active_d;
			cnt_q      <= cnt_d;
			idx_q      <= idx_d;
			phase_q    <= phase_d;
			neg_q      <= neg_d;
			acc_q      <= acc_d;
			ovf_q      <= ovf_d;
			in_range_q <= in_range_d;
			pdebug_q   <= pdebug_d;
			pflags_q   <= pflags_d;
			cal_pos_q  <= cal_pos_d;
			cal_ok_q   <= cal_ok_d;
			hdebug_q   <= hdebug_d;
			hflags_q   <= hflags_d;
			hvalid_q   <= hvalid_d;
		end
	end

	// Result of this byte
	assign res.status        = status;
	assign res.calib_request = calib;
	assign res.ctrl_valid    = hvalid_d;
	assign res.debug_mode    = hdebug_d;
	assign res.flags         = hflags_d;

endmodule

// ===== hw/rtl/ascii_control_frame_parser_unit.sv =====
// Top level of the ASCII control frame parser: beat registers, config registers, checks.
//
// Usage:
//   Slave side takes one received byte per beat: s_tdata[7:0] is the byte,
//   s_tuser[0] the link it came from (0 serial, 1 I2C). Master side returns
//   exactly one result beat per input beat, in order, with the frame status,
//   the calibration pulse and the held control word.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata, one register
//   per cycle, while no beat is in flight.
// Pipeline and throughput:
//   A byte is parsed while it sits in the input register; its result beat is
//   then registered and offered on the master side. One beat is taken every
//   cycle unless the master side stalls; the frame state update is a closed loop.
// Reset:
//   arst_n clears the valid flags of both beat registers, the frame state and the held control
//   word; the mode register comes up as "not available" so no link is allowed.
// Stall:
//   While the master side is stalled the result holds, the input register
//   keeps its byte, and s_tready drops once both registers are full.
module ascii_control_frame_parser_unit import acfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] link
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [1:0] status, [2] calib_request, [3] ctrl_valid,
	                               // [7:4] debug_mode, [8] watchdog_suppress,
	                               // [9] debugger_supply, [10] relay_one,
	                               // [11] relay_two, [12] relay_ext, [15:13] zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [3:0]  cfg_wdata
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       link_s1;
	logic       out_valid_q;
	res_t       out_q;
	res_t       res;
	logic       advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.op_mode     <= MODE_NONE;
			cfg_q.dbg_min     <= 4'd0;
			cfg_q.dbg_max_loc <= 4'd3;
			cfg_q.dbg_max_mst <= 4'd7;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_OP_MODE:     cfg_q.op_mode     <= cfg_wdata[1:0];
				REG_DBG_MIN:     cfg_q.dbg_min     <= cfg_wdata;
				REG_DBG_MAX_LOC: cfg_q.dbg_max_loc <= cfg_wdata;
				REG_DBG_MAX_MST: cfg_q.dbg_max_mst <= cfg_wdata;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	// Advance the parse stage when the result register is free or drains
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			link_s1 <= s_tuser[0];
		end
	end

	acfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.rx_byte (byte_s1),
		.link    (link_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q};

	// A calibration pulse only comes with an accepted frame
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.calib_request |-> out_q.status == ST_ACCEPT)
		else $error("calibration pulse without accepted status");

	// Status never carries the unused code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_q.status <= ST_REJECT)
		else $error("undefined status code");

	// Back-pressure only when both registers are full and the sink stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a full pipeline");

	// An accepted ordinary frame always leaves the control word valid
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.status == ST_ACCEPT && !out_q.calib_request |-> out_q.ctrl_valid)
		else $error("accepted frame left control word invalid");

endmodule
